### src/lpeg_pkg.sv
package lpeg_pkg;

  // Field widths of the channels, the speed register and the phases.
  localparam int MODE_W  = 2;
  localparam int INDEX_W = 3;
  localparam int CHAN_W  = 8;
  localparam int COUNT_W = 4;
  localparam int LED_W   = 6;
  localparam int SPEED_W = 8;
  localparam int PHASE_W = 16;

  // Configuration port.
  localparam int APB_AW  = 3;
  localparam int APB_DW  = 32;
  localparam int REG_BIT = 2;
  localparam logic REG_EFFECT = 1'b0;
  localparam logic REG_SPEED  = 1'b1;

  // Request codes.
  typedef enum logic [MODE_W-1:0] {
    MODE_TICK  = 2'd0,
    MODE_WRITE = 2'd1,
    MODE_COUNT = 2'd2
  } mode_e;

  // Effect codes.
  typedef enum logic [1:0] {
    EFF_STATIC  = 2'd0,
    EFF_BREATHE = 2'd1,
    EFF_RUNNER  = 2'd2,
    EFF_SCROLL  = 2'd3
  } effect_e;

  localparam logic [PHASE_W-1:0] BREATHE_STEP = 16'd655;
  localparam logic [PHASE_W-1:0] COLOR_STEP   = 16'd66;
  localparam logic [SPEED_W-1:0] SPEED_RESET  = 8'd128;

  // Commands from the controller and status back from the datapath.
  typedef struct packed {
    logic start;
    logic issue;
    logic pal_wr;
    logic set_cnt;
    logic finish;
  } lpeg_cmd_t;

  typedef struct packed {
    logic adv;
    logic last_pix;
    logic busy;
  } lpeg_sts_t;

  typedef logic [7:0]  lut8_t  [256];
  typedef logic [15:0] lut16_t [256];

  // Exact gamma 2.2: count of k with (2k-1)^5 * 255^6 <= 32 * v^11.
  function automatic lut8_t build_gamma_lut();
    lut8_t lut;
    logic [127:0] rhs;
    logic [127:0] lhs;
    logic [127:0] odd;
    int g;
    logic done;
    g = 0;
    for (int v = 0; v < 256; v++) begin
      rhs = 128'd32;
      for (int i = 0; i < 11; i++) rhs = rhs * 128'(v);
      done = 1'b0;
      while (!done && g < 255) begin
        odd = 128'(2 * (g + 1) - 1);
        lhs = 128'd1;
        for (int i = 0; i < 5; i++) lhs = lhs * odd;
        for (int i = 0; i < 6; i++) lhs = lhs * 128'd255;
        if (lhs <= rhs) g = g + 1;
        else done = 1'b1;
      end
      lut[v] = 8'(g);
    end
    return lut;
  endfunction

  // Q16 sine over the quarter wave, odd Taylor polynomial with Q30 terms.
  function automatic longint quarter_sine(longint j);
    longint t2;
    longint acc;
    t2  = j * j;
    acc = 172272;
    acc = acc * t2 / 4096 - 5026995;
    acc = acc * t2 / 4096 + 85569306;
    acc = acc * t2 / 4096 - 693598675;
    acc = acc * t2 / 4096 + 1686629713;
    acc = acc * j / 64 / 16384;
    if (acc < 0) acc = 0;
    if (acc > 65536) acc = 65536;
    return acc;
  endfunction

  // Breathing level for each of 256 phase steps.
  function automatic lut8_t build_breathe_lut();
    lut8_t lut;
    longint s;
    int q;
    int quad;
    for (int p = 0; p < 256; p++) begin
      q    = p % 64;
      quad = p / 64;
      if (quad % 2 == 1) s = quarter_sine(64 - q);
      else s = quarter_sine(q);
      if (quad >= 2) s = -s;
      lut[p] = 8'((s + 65536) * 255 >> 17);
    end
    return lut;
  endfunction

  // Per-frame phase advance as a function of the speed register.
  function automatic lut16_t build_scroll_lut();
    lut16_t lut;
    for (int s = 0; s < 256; s++) lut[s] = 16'((s * 65536 + 12750) / 25500);
    return lut;
  endfunction

  function automatic lut16_t build_runner_lut();
    lut16_t lut;
    for (int s = 0; s < 256; s++) lut[s] = 16'((s * 32768 + 12750) / 25500);
    return lut;
  endfunction

  localparam lut8_t  GAMMA_LUT   = build_gamma_lut();
  localparam lut8_t  BREATHE_LUT = build_breathe_lut();
  localparam lut16_t SCROLL_LUT  = build_scroll_lut();
  localparam lut16_t RUNNER_LUT  = build_runner_lut();

endpackage

### src/lpeg_if.sv
// Request channel into the generator.
interface lpeg_in_if import lpeg_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [MODE_W-1:0]  mode;
  logic [INDEX_W-1:0] index;
  logic [CHAN_W-1:0]  red;
  logic [CHAN_W-1:0]  green;
  logic [CHAN_W-1:0]  blue;
  logic [COUNT_W-1:0] count;

  modport source (output valid, mode, index, red, green, blue, count, input ready);
  modport sink (input valid, mode, index, red, green, blue, count, output ready);
endinterface

// Pixel channel out of the generator.
interface lpeg_out_if import lpeg_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [LED_W-1:0]  led_index;
  logic [CHAN_W-1:0] out_red;
  logic [CHAN_W-1:0] out_green;
  logic [CHAN_W-1:0] out_blue;
  logic              last;

  modport source (output valid, led_index, out_red, out_green, out_blue, last, input ready);
  modport sink (input valid, led_index, out_red, out_green, out_blue, last, output ready);
endinterface

### src/lpeg_ctrl.sv
module lpeg_ctrl import lpeg_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [MODE_W-1:0] mode_i,
  output logic              in_ready_o,
  input  lpeg_sts_t         sts_i,
  output lpeg_cmd_t         cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RENDER,
    ST_DRAIN
  } state_e;

  state_e state_q;
  state_e state_d;
  logic   fire;

  // Requests are taken only while no frame is in flight.
  assign in_ready_o = (state_q == ST_IDLE);
  assign fire       = in_valid_i && in_ready_o;

  // Command decode.
  always_comb begin
    cmd_o.start   = fire && (mode_i == MODE_TICK);
    cmd_o.pal_wr  = fire && (mode_i == MODE_WRITE);
    cmd_o.set_cnt = fire && (mode_i == MODE_COUNT);
    cmd_o.issue   = (state_q == ST_RENDER) && sts_i.adv;
    cmd_o.finish  = cmd_o.issue && sts_i.last_pix;
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_o.start) state_d = ST_RENDER;
      end
      ST_RENDER: begin
        if (cmd_o.finish) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!sts_i.busy) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // The pixel pipeline is empty whenever new requests can be taken.
  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> !sts_i.busy)
    else $error("pixel pipeline busy while idle");

  // A frame only starts rendering after a tick request.
  a_render_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(state_q == ST_RENDER) |-> $past(cmd_o.start))
    else $error("render entered without a tick");

endmodule

### src/lpeg_dp.sv
module lpeg_dp import lpeg_pkg::*; #(
  parameter int LED_COUNT    = 64,
  parameter int PALETTE_SIZE = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lpeg_cmd_t          cmd_i,
  output lpeg_sts_t          sts_o,
  input  effect_e            effect_i,
  input  logic [SPEED_W-1:0] speed_i,
  input  logic [INDEX_W-1:0] index_i,
  input  logic [CHAN_W-1:0]  red_i,
  input  logic [CHAN_W-1:0]  green_i,
  input  logic [CHAN_W-1:0]  blue_i,
  input  logic [COUNT_W-1:0] count_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [LED_W-1:0]   led_index_o,
  output logic [CHAN_W-1:0]  out_red_o,
  output logic [CHAN_W-1:0]  out_green_o,
  output logic [CHAN_W-1:0]  out_blue_o,
  output logic               last_o
);

  localparam int PW  = $clog2(PALETTE_SIZE);
  localparam int CW  = $clog2(PALETTE_SIZE + 1);
  localparam int LIW = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
  localparam int RW  = $clog2(LED_COUNT) + 1;
  localparam int PRW = PHASE_W + CW;
  localparam logic [16:0]    POS_STEP  = 17'(65536 / LED_COUNT);
  localparam logic [RW-1:0]  POS_REM   = RW'(65536 % LED_COUNT);
  localparam logic [RW-1:0]  REM_LIM   = RW'(LED_COUNT);
  localparam logic [LIW-1:0] LAST_PIX  = LIW'(LED_COUNT - 1);
  localparam logic [23:0]    PAL_WHITE = 24'hFFFFFF;

  // Blend of two channels: ((a<<8) + (b-a)*amt) >> 8.
  function automatic logic [7:0] blend8(logic [7:0] a, logic [7:0] b, logic [7:0] amt);
    logic signed [8:0]  diff;
    logic signed [17:0] acc;
    diff = $signed({1'b0, b}) - $signed({1'b0, a});
    acc  = diff * $signed({1'b0, amt}) + $signed({2'b00, a, 8'h00});
    return acc[15:8];
  endfunction

  // Video scaling: a lit channel never goes fully dark unless the level is zero.
  function automatic logic [7:0] scale8(logic [7:0] c, logic [7:0] lvl);
    logic [15:0] p;
    p = c * lvl;
    return p[15:8] + {7'd0, (c != 8'd0) && (lvl != 8'd0)};
  endfunction

  // State registers.
  logic [CW-1:0]      cnt_q;
  logic [PHASE_W-1:0] breathe_q;
  logic [PHASE_W-1:0] color_q;
  logic [PHASE_W-1:0] runner_q;
  logic [PHASE_W-1:0] scroll_q;
  logic [7:0]         level_q;
  logic [23:0]        pal_mem [PALETTE_SIZE];
  logic [PALETTE_SIZE-1:0] pal_vld_q;

  // Pixel walk.
  logic [LIW-1:0]     pix_q;
  logic [PHASE_W-1:0] pos_q;
  logic [RW-1:0]      rem_q;
  logic [RW-1:0]      rem_sum;

  // Pipeline.
  logic               adv;
  logic               v1_q, v2_q, v3_q, v4_q;
  logic [PRW-1:0]     prod_q;
  logic [LIW-1:0]     idx1_q, idx2_q, idx3_q, idx4_q;
  logic               last1_q, last2_q, last3_q, last4_q;
  logic [23:0]        rd_a_q, rd_b_q;
  logic [7:0]         amt_q;
  logic [23:0]        bl_q;
  logic [23:0]        px_q;

  logic [PHASE_W-1:0] pos_sel;
  logic [CW-1:0]      span;
  logic [PRW-1:0]     prod_d;
  logic [CW-1:0]      i1c, i2c;
  logic [PHASE_W-1:0] frac;
  logic [23:0]        amt_full;
  logic [7:0]         amt_d;
  logic [PW-1:0]      addr_a, addr_b;
  logic               wr_ok;
  logic [PW-1:0]      wr_addr;
  logic [CW-1:0]      wr_cnt;

  assign adv          = !v4_q || out_ready_i;
  assign sts_o.adv      = adv;
  assign sts_o.last_pix = (pix_q == LAST_PIX);
  assign sts_o.busy     = v1_q || v2_q || v3_q || v4_q;

  // Palette write decode.
  assign wr_ok   = int'(index_i) < PALETTE_SIZE;
  assign wr_addr = PW'(index_i);
  assign wr_cnt  = CW'(index_i) + CW'(1);

  // Colour count, palette valid flags and effect phases.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= CW'(1);
      breathe_q <= '0;
      color_q   <= '0;
      runner_q  <= '0;
      scroll_q  <= '0;
      pal_vld_q <= '0;
    end else begin
      if (cmd_i.pal_wr && wr_ok) begin
        pal_vld_q[wr_addr] <= 1'b1;
        if (wr_cnt > cnt_q) cnt_q <= wr_cnt;
      end
      if (cmd_i.set_cnt) begin
        if (count_i == '0) cnt_q <= CW'(1);
        else if (int'(count_i) > PALETTE_SIZE) cnt_q <= CW'(PALETTE_SIZE);
        else cnt_q <= CW'(count_i);
      end
      if (cmd_i.start && effect_i == EFF_SCROLL) begin
        scroll_q <= scroll_q + SCROLL_LUT[speed_i];
      end
      if (cmd_i.finish && effect_i == EFF_BREATHE) begin
        breathe_q <= breathe_q + BREATHE_STEP;
        color_q   <= color_q + COLOR_STEP;
      end
      if (cmd_i.finish && effect_i == EFF_RUNNER) begin
        runner_q <= runner_q + RUNNER_LUT[speed_i];
      end
    end
  end

  // Palette storage, written through the gamma table, and the breathing level.
  always_ff @(posedge clk_i) begin
    if (cmd_i.pal_wr && wr_ok) begin
      pal_mem[wr_addr] <= {GAMMA_LUT[red_i], GAMMA_LUT[green_i], GAMMA_LUT[blue_i]};
    end
    if (cmd_i.start) begin
      level_q <= BREATHE_LUT[breathe_q[15:8]];
    end
  end

  // Pixel position walk: floor(i * 65536 / LED_COUNT) by step and remainder.
  assign rem_sum = rem_q + POS_REM;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_q <= '0;
      pos_q <= '0;
      rem_q <= '0;
    end else if (cmd_i.start) begin
      pix_q <= '0;
      pos_q <= '0;
      rem_q <= '0;
    end else if (cmd_i.issue) begin
      pix_q <= pix_q + LIW'(1);
      if (rem_sum >= REM_LIM) begin
        rem_q <= rem_sum - REM_LIM;
        pos_q <= pos_q + POS_STEP[15:0] + 16'd1;
      end else begin
        rem_q <= rem_sum;
        pos_q <= pos_q + POS_STEP[15:0];
      end
    end
  end

  // Stage 1: position and span product.
  always_comb begin
    unique case (effect_i)
      EFF_STATIC:  pos_sel = pos_q;
      EFF_BREATHE: pos_sel = color_q;
      EFF_RUNNER:  pos_sel = pos_q + runner_q;
      EFF_SCROLL:  pos_sel = pos_q + scroll_q;
      default:     pos_sel = pos_q;
    endcase
    span   = (effect_i == EFF_SCROLL) ? cnt_q : cnt_q - CW'(1);
    prod_d = PRW'(pos_sel) * PRW'(span);
  end

  // Stage 2: entry indexes and blend amount.
  always_comb begin
    i1c      = prod_q[PRW-1:PHASE_W];
    frac     = prod_q[PHASE_W-1:0];
    amt_full = {frac, 8'h00} - {8'h00, frac};
    amt_d    = amt_full[23:16];
    if (effect_i == EFF_SCROLL) begin
      i2c = (i1c + CW'(1) >= cnt_q) ? '0 : i1c + CW'(1);
    end else begin
      i2c = i1c + CW'(frac != '0);
    end
    if (effect_i == EFF_STATIC) begin
      i1c   = '0;
      i2c   = '0;
      amt_d = '0;
    end
    addr_a = PW'(i1c);
    addr_b = PW'(i2c);
  end

  // Pipeline valid flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (adv) begin
      v1_q <= cmd_i.issue;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  // Pipeline payload, including the registered palette reads.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      prod_q  <= prod_d;
      idx1_q  <= pix_q;
      last1_q <= sts_o.last_pix;

      rd_a_q  <= pal_vld_q[addr_a] ? pal_mem[addr_a] : ((addr_a == '0) ? PAL_WHITE : '0);
      rd_b_q  <= pal_vld_q[addr_b] ? pal_mem[addr_b] : ((addr_b == '0) ? PAL_WHITE : '0);
      amt_q   <= amt_d;
      idx2_q  <= idx1_q;
      last2_q <= last1_q;

      bl_q    <= {blend8(rd_a_q[23:16], rd_b_q[23:16], amt_q),
                  blend8(rd_a_q[15:8],  rd_b_q[15:8],  amt_q),
                  blend8(rd_a_q[7:0],   rd_b_q[7:0],   amt_q)};
      idx3_q  <= idx2_q;
      last3_q <= last2_q;

      if (effect_i == EFF_BREATHE) begin
        px_q <= {scale8(bl_q[23:16], level_q), scale8(bl_q[15:8], level_q),
                 scale8(bl_q[7:0], level_q)};
      end else begin
        px_q <= bl_q;
      end
      idx4_q  <= idx3_q;
      last4_q <= last3_q;
    end
  end

  assign out_valid_o = v4_q;
  assign led_index_o = LED_W'(idx4_q);
  assign out_red_o   = px_q[23:16];
  assign out_green_o = px_q[15:8];
  assign out_blue_o  = px_q[7:0];
  assign last_o      = last4_q;

  // The colour count never leaves its saturated range.
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != '0 && int'(cnt_q) <= PALETTE_SIZE)
    else $error("colour count out of range");

  // The last flag marks the final pixel position.
  a_last_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v4_q && last4_q |-> idx4_q == LAST_PIX)
    else $error("last flag on wrong pixel");

  // Pixels are only issued into a moving pipeline.
  a_issue_adv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.issue |-> adv)
    else $error("pixel issued while stalled");

endmodule

### src/led_palette_effect_generator.sv
// Palette write and colour count requests leave the controller idle, so the
// next request can be taken straight away. A frame tick streams LED_COUNT
// pixels at one per cycle while the sink is ready, through a four-stage pixel
// pipe. The next request is taken once the pipe has drained.
// Reset: palette entry zero white and the rest black, one colour, all phases
// zero, static effect, speed 128.
module led_palette_effect_generator import lpeg_pkg::*; #(
  parameter int LED_COUNT    = 64,
  parameter int PALETTE_SIZE = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  lpeg_in_if.sink           in_if,
  lpeg_out_if.source        out_if,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  effect_e            effect_q;
  logic [SPEED_W-1:0] speed_q;
  logic               reg_wr;
  lpeg_cmd_t          cmd;
  lpeg_sts_t          sts;

  // Configuration registers.
  assign pready = 1'b1;
  assign reg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      effect_q <= EFF_STATIC;
      speed_q  <= SPEED_RESET;
    end else if (reg_wr) begin
      unique case (paddr[REG_BIT])
        REG_EFFECT: effect_q <= effect_e'(pwdata[1:0]);
        REG_SPEED:  speed_q  <= pwdata[SPEED_W-1:0];
        default:    speed_q  <= speed_q;
      endcase
    end
  end

  // Register readback.
  always_comb begin
    unique case (paddr[REG_BIT])
      REG_EFFECT: prdata = {30'd0, effect_q};
      REG_SPEED:  prdata = {24'd0, speed_q};
      default:    prdata = '0;
    endcase
  end

  lpeg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .mode_i     (in_if.mode),
    .in_ready_o (in_if.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lpeg_dp #(
    .LED_COUNT    (LED_COUNT),
    .PALETTE_SIZE (PALETTE_SIZE)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .effect_i    (effect_q),
    .speed_i     (speed_q),
    .index_i     (in_if.index),
    .red_i       (in_if.red),
    .green_i     (in_if.green),
    .blue_i      (in_if.blue),
    .count_i     (in_if.count),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .led_index_o (out_if.led_index),
    .out_red_o   (out_if.out_red),
    .out_green_o (out_if.out_green),
    .out_blue_o  (out_if.out_blue),
    .last_o      (out_if.last)
  );

endmodule
